// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL of the heap allocator, used by its top level.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/fbha_pkg.sv -----
// Package for the heap allocator: request/result types, codes and the
// controller/datapath command set. No dependencies.
`timescale 1ns / 1ps

package fbha_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_size;
        logic [15:0] free_offset;
    } in_t;

    typedef struct packed {
        logic [15:0] block_offset;
        logic [15:0] granted_size;
        logic [2:0]  status;
        logic [15:0] free_total;
    } out_t;

    localparam logic [1:0] OP_FIRST = 2'd0;
    localparam logic [1:0] OP_BEST  = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOFREE = 3'd1;
    localparam logic [2:0] ST_NOFIT  = 3'd2;
    localparam logic [2:0] ST_BADH   = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef logic [3:0] cmd_t;

    localparam cmd_t CMD_IDLE     = 4'd0;
    localparam cmd_t CMD_INIT     = 4'd1;
    localparam cmd_t CMD_START    = 4'd2;
    localparam cmd_t CMD_ASCAN    = 4'd3;
    localparam cmd_t CMD_AEND     = 4'd4;
    localparam cmd_t CMD_UP       = 4'd5;
    localparam cmd_t CMD_SPLIT_LO = 4'd6;
    localparam cmd_t CMD_SPLIT_HI = 4'd7;
    localparam cmd_t CMD_FSCAN    = 4'd8;
    localparam cmd_t CMD_FMERGE   = 4'd9;
    localparam cmd_t CMD_DOWN     = 4'd10;
    localparam cmd_t CMD_LOAD     = 4'd11;

    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic scan_end;
        logic ff_hit;
        logic alloc_fail;
        logic split;
        logic up_more;
        logic free_hit;
        logic merge_any;
    } stat_t;

endpackage

// ----- sv/fbha_ctrl.sv -----
// Controller state machine of the heap allocator.
// Depends on fbha_pkg for the command codes and the datapath status struct.
`timescale 1ns / 1ps

module fbha_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  fbha_pkg::stat_t stat,
    output fbha_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_ASCAN = 4'd3;
    localparam logic [3:0] S_AEND  = 4'd4;
    localparam logic [3:0] S_UP    = 4'd5;
    localparam logic [3:0] S_SPLO  = 4'd6;
    localparam logic [3:0] S_SPHI  = 4'd7;
    localparam logic [3:0] S_FSCAN = 4'd8;
    localparam logic [3:0] S_FMRG  = 4'd9;
    localparam logic [3:0] S_DOWN  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = fbha_pkg::CMD_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd        = fbha_pkg::CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = fbha_pkg::CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (stat.is_alloc)
                    state_next = S_ASCAN;
                else if (stat.is_free)
                    state_next = S_FSCAN;
                else
                    state_next = S_DONE;
            end
            S_ASCAN:
            begin
                cmd = fbha_pkg::CMD_ASCAN;
                if (stat.scan_end || stat.ff_hit)
                    state_next = S_AEND;
            end
            S_AEND:
            begin
                cmd = fbha_pkg::CMD_AEND;
                if (!stat.alloc_fail && stat.split)
                    state_next = S_UP;
                else
                    state_next = S_DONE;
            end
            S_UP:
            begin
                cmd = fbha_pkg::CMD_UP;
                if (!stat.up_more)
                    state_next = S_SPLO;
            end
            S_SPLO:
            begin
                cmd        = fbha_pkg::CMD_SPLIT_LO;
                state_next = S_SPHI;
            end
            S_SPHI:
            begin
                cmd        = fbha_pkg::CMD_SPLIT_HI;
                state_next = S_DONE;
            end
            S_FSCAN:
            begin
                cmd = fbha_pkg::CMD_FSCAN;
                if (stat.scan_end)
                    state_next = S_DONE;
                else if (stat.free_hit)
                    state_next = S_FMRG;
            end
            S_FMRG:
            begin
                cmd        = fbha_pkg::CMD_FMERGE;
                state_next = stat.merge_any ? S_DOWN : S_DONE;
            end
            S_DOWN:
            begin
                cmd = fbha_pkg::CMD_DOWN;
                if (stat.scan_end)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd        = fbha_pkg::CMD_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd == fbha_pkg::CMD_LOAD)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- sv/fbha_dp.sv -----
// Datapath of the heap allocator: block table memory, scan registers and
// the result register. Depends on fbha_pkg; driven by fbha_ctrl commands.
`timescale 1ns / 1ps

module fbha_dp
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  fbha_pkg::cmd_t   cmd,
    output fbha_pkg::stat_t  stat,
    input  fbha_pkg::in_t    in_data,
    input  logic [15:0]      heap_size,
    input  logic             cfg_wr,
    input  logic [15:0]      cfg_value,
    output fbha_pkg::out_t   out_data
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef struct packed {
        logic        used;
        logic [15:0] size;
    } ent_t;

    ent_t mem [MAX_BLOCKS];
    ent_t rd_data_reg;

    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    op_reg, op_next;
    logic [15:0]   req_reg, req_next;
    logic [15:0]   foff_reg, foff_next;
    logic [15:0]   off_reg, off_next;
    logic          any_free_reg, any_free_next;
    logic          found_reg, found_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [15:0]   pick_size_reg, pick_size_next;
    logic [15:0]   pick_off_reg, pick_off_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [15:0]   cur_reg, cur_next;
    logic          prev_used_reg, prev_used_next;
    logic [15:0]   prev_size_reg, prev_size_next;
    logic [1:0]    dist_reg, dist_next;
    logic [15:0]   free_reg, free_next;
    logic [15:0]   res_off_reg, res_off_next;
    logic [15:0]   res_size_reg, res_size_next;
    logic [2:0]    res_status_reg, res_status_next;
    fbha_pkg::out_t out_reg, out_next;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    ent_t          wr_data;

    logic          scan_end;
    logic          fit;
    logic          match;
    logic          upper_free;
    logic          lower_free;
    logic          split_need;
    logic          full;
    logic [16:0]   req_up;
    logic [16:0]   want17;
    logic [15:0]   want;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_back;
    logic [CW-1:0] pick_inc;
    logic [CW-1:0] idx_two;

    always_comb
    begin
        scan_end   = ptr_reg >= count_reg;
        fit        = !rd_data_reg.used && (rd_data_reg.size >= req_reg);
        match      = rd_data_reg.used && (off_reg == foff_reg);
        upper_free = !scan_end && !rd_data_reg.used;
        lower_free = !prev_used_reg;
        // Round up to the 8-unit grain; a zero request still takes one grain.
        req_up     = {1'b0, req_reg} + 17'd7;
        want17     = (req_up[16:3] == 14'd0) ? 17'd8 : {req_up[16:3], 3'b000};
        want       = want17[15:0];
        split_need = want17 < {1'b0, pick_size_reg};
        full       = count_reg == CW'(MAX_BLOCKS);
        ptr_inc    = ptr_reg + 1'b1;
        ptr_back   = ptr_reg - CW'(dist_reg);
        pick_inc   = CW'(pick_reg) + 1'b1;
        idx_two    = CW'(idx_reg) + CW'(2);
    end

    always_comb
    begin
        stat.is_alloc   = (op_reg == fbha_pkg::OP_FIRST) || (op_reg == fbha_pkg::OP_BEST);
        stat.is_free    = op_reg == fbha_pkg::OP_FREE;
        stat.scan_end   = scan_end;
        stat.ff_hit     = !scan_end && fit && !found_reg && (op_reg == fbha_pkg::OP_FIRST);
        stat.alloc_fail = !any_free_reg || !found_reg || (split_need && full);
        stat.split      = split_need;
        stat.up_more    = ptr_reg > CW'(pick_reg);
        stat.free_hit   = !scan_end && match;
        stat.merge_any  = lower_free || upper_free;
    end

    always_comb
    begin
        ptr_next        = ptr_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        foff_next       = foff_reg;
        off_next        = off_reg;
        any_free_next   = any_free_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        pick_off_next   = pick_off_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        prev_used_next  = prev_used_reg;
        prev_size_next  = prev_size_reg;
        dist_next       = dist_reg;
        free_next       = free_reg;
        res_off_next    = res_off_reg;
        res_size_next   = res_size_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;

        case (cmd)
            fbha_pkg::CMD_INIT:
            begin
                wr_en      = 1'b1;
                wr_data    = '{used: 1'b0, size: heap_size};
                free_next  = heap_size;
                count_next = CW'(1);
            end
            fbha_pkg::CMD_START:
            begin
                op_next         = in_data.opcode;
                req_next        = in_data.request_size;
                foff_next       = in_data.free_offset;
                ptr_next        = '0;
                off_next        = '0;
                any_free_next   = 1'b0;
                found_next      = 1'b0;
                prev_used_next  = 1'b1;
                res_off_next    = '0;
                res_size_next   = '0;
                res_status_next = fbha_pkg::ST_OK;
            end
            fbha_pkg::CMD_ASCAN:
            begin
                if (!scan_end)
                begin
                    if (!rd_data_reg.used)
                        any_free_next = 1'b1;
                    if (fit && (!found_reg || (rd_data_reg.size < pick_size_reg)))
                    begin
                        found_next     = 1'b1;
                        pick_next      = ptr_reg[IW-1:0];
                        pick_size_next = rd_data_reg.size;
                        pick_off_next  = off_reg;
                    end
                    off_next = off_reg + rd_data_reg.size;
                    ptr_next = ptr_inc;
                end
            end
            fbha_pkg::CMD_AEND:
            begin
                if (!any_free_reg)
                    res_status_next = fbha_pkg::ST_NOFREE;
                else if (!found_reg)
                    res_status_next = fbha_pkg::ST_NOFIT;
                else if (split_need)
                begin
                    if (full)
                        res_status_next = fbha_pkg::ST_FULL;
                    else
                        ptr_next = count_reg - 1'b1;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = pick_reg;
                    wr_data       = '{used: 1'b1, size: pick_size_reg};
                    res_off_next  = pick_off_reg;
                    res_size_next = pick_size_reg;
                    free_next     = free_reg - pick_size_reg;
                end
            end
            fbha_pkg::CMD_UP:
            begin
                // Open a hole above the picked block, moving the top entry first.
                if (ptr_reg > CW'(pick_reg))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_inc[IW-1:0];
                    wr_data  = rd_data_reg;
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            fbha_pkg::CMD_SPLIT_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = pick_reg;
                wr_data = '{used: 1'b0, size: pick_size_reg - want};
            end
            fbha_pkg::CMD_SPLIT_HI:
            begin
                wr_en         = 1'b1;
                wr_addr       = pick_inc[IW-1:0];
                wr_data       = '{used: 1'b1, size: want};
                count_next    = count_reg + 1'b1;
                res_off_next  = pick_off_reg + (pick_size_reg - want);
                res_size_next = want;
                free_next     = free_reg - want;
            end
            fbha_pkg::CMD_FSCAN:
            begin
                if (scan_end)
                    res_status_next = fbha_pkg::ST_BADH;
                else if (match)
                begin
                    idx_next = ptr_reg[IW-1:0];
                    cur_next = rd_data_reg.size;
                    ptr_next = ptr_inc;
                end
                else
                begin
                    prev_used_next = rd_data_reg.used;
                    prev_size_next = rd_data_reg.size;
                    off_next       = off_reg + rd_data_reg.size;
                    ptr_next       = ptr_inc;
                end
            end
            fbha_pkg::CMD_FMERGE:
            begin
                // The entry after the freed one is on the read port here.
                free_next = free_reg + cur_reg;
                wr_en     = 1'b1;
                if (lower_free && upper_free)
                begin
                    wr_addr   = idx_reg - 1'b1;
                    wr_data   = '{used: 1'b0,
                                  size: prev_size_reg + cur_reg + rd_data_reg.size};
                    ptr_next  = idx_two;
                    dist_next = 2'd2;
                end
                else if (lower_free)
                begin
                    wr_addr   = idx_reg - 1'b1;
                    wr_data   = '{used: 1'b0, size: prev_size_reg + cur_reg};
                    ptr_next  = ptr_reg;
                    dist_next = 2'd1;
                end
                else if (upper_free)
                begin
                    wr_addr   = idx_reg;
                    wr_data   = '{used: 1'b0, size: cur_reg + rd_data_reg.size};
                    ptr_next  = idx_two;
                    dist_next = 2'd1;
                end
                else
                begin
                    wr_addr = idx_reg;
                    wr_data = '{used: 1'b0, size: cur_reg};
                end
            end
            fbha_pkg::CMD_DOWN:
            begin
                if (!scan_end)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_back[IW-1:0];
                    wr_data  = rd_data_reg;
                    ptr_next = ptr_inc;
                end
                else
                    count_next = count_reg - CW'(dist_reg);
            end
            fbha_pkg::CMD_LOAD:
            begin
                out_next = '{block_offset: res_off_reg, granted_size: res_size_reg,
                             status: res_status_reg, free_total: free_reg};
            end
            default:
            begin
            end
        endcase

        // A heap size write restarts the table with one free block.
        if (cfg_wr)
        begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = '{used: 1'b0, size: cfg_value};
            free_next  = cfg_value;
            count_next = CW'(1);
        end
    end

    // Read address follows the next pointer so the data lines up with ptr_reg.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[ptr_next[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(1);
            ptr_reg   <= '0;
            op_reg    <= fbha_pkg::OP_FIRST;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        foff_reg       <= foff_next;
        off_reg        <= off_next;
        any_free_reg   <= any_free_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_size_reg  <= pick_size_next;
        pick_off_reg   <= pick_off_next;
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        prev_used_reg  <= prev_used_next;
        prev_size_reg  <= prev_size_next;
        dist_reg       <= dist_next;
        free_reg       <= free_next;
        res_off_reg    <= res_off_next;
        res_size_reg   <= res_size_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ----- sv/first_best_fit_heap_allocator_unit.sv -----
// Top level of the heap allocator: configuration port, controller and datapath.
// Depends on fbha_pkg, fbha_ctrl, fbha_dp and assert_macros.svh.
//
//   Channel | Handshake                        | Payload
//   in      | in_valid / in_ready              | in_data  (fbha_pkg::in_t)
//   out     | out_valid / out_ready            | out_data (fbha_pkg::out_t)
//   config  | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A request walks the block table one entry per cycle through the single
// memory read port, and a split or a merge that reshapes the table moves
// the entries above the changed block one by one. After reset the INIT
// state loads the initial block before the first request is taken.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module first_best_fit_heap_allocator_unit
#(
    parameter int MAX_BLOCKS = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fbha_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fbha_pkg::out_t out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [15:0]     heap_reg;
    logic            cfg_wr;
    fbha_pkg::cmd_t  cmd;
    fbha_pkg::stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, heap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            heap_reg <= 16'd4096;
        else if (cfg_wr)
            heap_reg <= pwdata[15:0];
    end

    fbha_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fbha_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .heap_size (heap_reg),
        .cfg_wr    (cfg_wr),
        .cfg_value (pwdata[15:0]),
        .out_data  (out_data)
    );

    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_fail_no_grant, out_valid && (out_data.status != fbha_pkg::ST_OK), (out_data.block_offset == 16'd0) && (out_data.granted_size == 16'd0))
    `ASSERT_SAME(a_free_bounded, out_valid, out_data.free_total <= heap_reg)

endmodule
